FILE: sv/mmmes_pkg.sv
// Shared types and codes for the min/max/median extract store.
package mmmes_pkg;

	localparam int DATA_W = 32;

	// Operation codes carried in the request item
	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_MEDIAN = 2'd1,
		OP_MIN    = 2'd2,
		OP_MAX    = 2'd3
	} opcode_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]               opcode;
		logic signed [DATA_W-1:0] operand;
	} req_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		logic [1:0]               status;
	} rsp_item_t;

	// Broadcast command to every cell of the sorted chain
	typedef struct packed {
		logic                     add_en;
		logic                     ext_en;
		logic signed [DATA_W-1:0] ins_value;
	} cell_cmd_t;

	// Control tag that travels with the reduction tree
	typedef struct packed {
		logic       valid;
		logic [1:0] status;
	} tree_tag_t;

endpackage

FILE: sv/mmmes_cell.sv
// One position of the sorted shift-register chain.
module mmmes_cell #(
	parameter int IDX = 0,
	parameter int CW  = 7,
	parameter int IW  = 6
) (
	input  logic                                clk,
	input  mmmes_pkg::cell_cmd_t                cmd,
	input  logic [CW-1:0]                       count,
	input  logic [IW-1:0]                       pos,
	input  logic signed [mmmes_pkg::DATA_W-1:0] left_value,
	input  logic                                left_lt,
	input  logic signed [mmmes_pkg::DATA_W-1:0] right_value,
	output logic signed [mmmes_pkg::DATA_W-1:0] value,
	output logic                                lt,
	output logic [mmmes_pkg::DATA_W-1:0]        pick
);

	logic signed [mmmes_pkg::DATA_W-1:0] value_q;
	logic                                occupied;
	logic                                at_pos;
	logic                                at_or_above;

	// Local decisions from own index and the broadcast count / position
	assign occupied    = (CW'(IDX) < count);
	assign at_pos      = (IW'(IDX) == pos);
	assign at_or_above = (IW'(IDX) >= pos);
	assign lt          = occupied && (value_q < cmd.ins_value);
	assign value       = value_q;

	// Extracted value leaves through the cell that matches the position
	assign pick = (cmd.ext_en && at_pos) ? value_q : '0;

	// Insert: keep smaller, take new value at the boundary, else shift right.
	// Extract: cells at or above the position pull from the right neighbor.
	always_ff @(posedge clk) begin
		if (cmd.add_en) begin
			if (!lt) begin
				if (left_lt) begin
					value_q <= cmd.ins_value;
				end else begin
					value_q <= left_value;
				end
			end
		end else if (cmd.ext_en && at_or_above) begin
			value_q <= right_value;
		end
	end

endmodule

FILE: sv/mmmes_or_tree.sv
// Registered OR-reduction tree that gathers the extracted value from all cells.
module mmmes_or_tree #(
	parameter int N = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [mmmes_pkg::DATA_W-1:0]  leaves [N],
	input  mmmes_pkg::tree_tag_t          in_tag,
	input  logic                          take,
	output logic [mmmes_pkg::DATA_W-1:0]  root_value,
	output mmmes_pkg::tree_tag_t          root_tag,
	output logic                          busy
);

	function automatic int calc_levels(int n);
		int l;
		int span;
		l    = 1;
		span = 8;
		while (span < n) begin
			l++;
			span = span * 8;
		end
		return l;
	endfunction

	localparam int LEVELS = calc_levels(N);
	localparam int PAD    = 8 ** LEVELS;

	logic [mmmes_pkg::DATA_W-1:0] leaf_pad [PAD];
	logic [mmmes_pkg::DATA_W-1:0] node_q [LEVELS][PAD];
	mmmes_pkg::tree_tag_t         tag_q [LEVELS];
	logic                         adv;
	logic [LEVELS-1:0]            valid_vec;

	// Pad the leaf row up to a full power of eight
	for (genvar j = 0; j < PAD; j++) begin : g_pad
		if (j < N) begin : g_real
			assign leaf_pad[j] = leaves[j];
		end else begin : g_zero
			assign leaf_pad[j] = '0;
		end
	end

	// Whole tree freezes only when the root holds an unclaimed result
	assign adv = !root_tag.valid || take;

	// Eight-way OR per node, one level per register stage
	always_ff @(posedge clk) begin
		logic [mmmes_pkg::DATA_W-1:0] acc;
		int                           width;
		int                           prev;
		if (adv) begin
			for (int l = 0; l < LEVELS; l++) begin
				width = PAD >> (3 * (l + 1));
				prev  = (l >= 1) ? (l - 1) : 0;
				for (int j = 0; j < PAD; j++) begin
					acc = '0;
					if (j < width) begin
						for (int k = 0; k < 8; k++) begin
							if (l == 0) begin
								acc = acc | leaf_pad[j * 8 + k];
							end else begin
								acc = acc | node_q[prev][j * 8 + k];
							end
						end
					end
					node_q[l][j] <= acc;
				end
			end
		end
	end

	// Tag shift line alongside the data levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++) begin
				tag_q[l] <= '0;
			end
		end else if (adv) begin
			tag_q[0] <= in_tag;
			for (int l = 1; l < LEVELS; l++) begin
				tag_q[l] <= tag_q[l - 1];
			end
		end
	end

	for (genvar l = 0; l < LEVELS; l++) begin : g_valid
		assign valid_vec[l] = tag_q[l].valid;
	end

	assign root_value = node_q[LEVELS - 1][0];
	assign root_tag   = tag_q[LEVELS - 1];
	assign busy       = |valid_vec;

	// At most one result travels through the tree at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) <= 1)
		else $error("more than one result in the reduction tree");

endmodule

FILE: sv/min_max_median_extract_store_core.sv
// Top level of the sorted multiset store with min/max/median extraction.
// Usage:
//   Request channel (req_valid/req_stall/req) carries one operation per item:
//   add a value, or extract the minimum, the maximum or the lower median.
//   Response channel (rsp_valid/rsp_stall/rsp) returns one item for every
//   extract and for every add that finds the store full; a successful add
//   returns nothing.
//   The values sit in a row of CAPACITY cells kept in ascending order; every
//   cell decides locally from its neighbors, so the store itself updates
//   at once for any operation.
//   The extracted value is gathered by an eight-way registered OR tree of
//   L = ceil(log8(CAPACITY)) stages (L = 2 at 64 entries), then an output
//   register.
//   Successful adds are taken one per cycle while req_stall is low; an item
//   that produces a result keeps req_stall high while it is in the tree, so
//   the next item is taken only once it has reached the output register.
//   A finished result waiting in the output register does not block new items.
//   When rsp_stall is high the result stays in the output register, a later
//   result waits at the tree root, and req_stall rises until it moves on.
//   Reset empties the store (count to zero) and clears all valid flags;
//   no clearing pass is needed.
module min_max_median_extract_store_core #(
	parameter int CAPACITY = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  mmmes_pkg::req_item_t req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output mmmes_pkg::rsp_item_t rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	logic [CW-1:0]                       count_q;
	logic [CW-1:0]                       count_m1;
	logic [IW-1:0]                       pos;
	logic                                accept;
	logic                                is_add;
	logic                                full;
	logic                                empty;
	logic                                add_ok;
	logic                                ext_ok;
	mmmes_pkg::cell_cmd_t                cmd;
	mmmes_pkg::tree_tag_t                in_tag;
	mmmes_pkg::tree_tag_t                root_tag;
	logic [mmmes_pkg::DATA_W-1:0]        root_value;
	logic                                tree_busy;
	logic                                take;
	logic                                rsp_valid_q;
	mmmes_pkg::rsp_item_t                rsp_q;

	logic signed [mmmes_pkg::DATA_W-1:0] cell_value [CAPACITY];
	logic                                cell_lt [CAPACITY];
	logic [mmmes_pkg::DATA_W-1:0]        cell_pick [CAPACITY];
	logic signed [mmmes_pkg::DATA_W-1:0] left_value [CAPACITY];
	logic                                left_lt [CAPACITY];
	logic signed [mmmes_pkg::DATA_W-1:0] right_value [CAPACITY];

	// Request decode
	assign req_stall = tree_busy;
	assign accept    = req_valid && !req_stall;
	assign is_add    = (req.opcode == mmmes_pkg::OP_ADD);
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign add_ok    = accept && is_add && !full;
	assign ext_ok    = accept && !is_add && !empty;
	assign count_m1  = count_q - CW'(1);

	// Position of the entry to remove
	always_comb begin
		case (req.opcode)
			mmmes_pkg::OP_MIN:    pos = '0;
			mmmes_pkg::OP_MAX:    pos = count_m1[IW-1:0];
			mmmes_pkg::OP_MEDIAN: pos = IW'(count_m1 >> 1);
			default:              pos = '0;
		endcase
	end

	assign cmd.add_en    = add_ok;
	assign cmd.ext_en    = ext_ok;
	assign cmd.ins_value = req.operand;

	// Tag for the result, if this item produces one
	always_comb begin
		in_tag.valid  = accept && !(is_add && !full);
		in_tag.status = mmmes_pkg::ST_OK;
		if (is_add) begin
			in_tag.status = mmmes_pkg::ST_FULL;
		end else if (empty) begin
			in_tag.status = mmmes_pkg::ST_EMPTY;
		end
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (add_ok) begin
			count_q <= count_q + CW'(1);
		end else if (ext_ok) begin
			count_q <= count_m1;
		end
	end

	// Sorted chain with neighbor links
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign left_value[i] = '0;
			assign left_lt[i]    = 1'b1;
		end else begin : g_mid
			assign left_value[i] = cell_value[i - 1];
			assign left_lt[i]    = cell_lt[i - 1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_value[i] = '0;
		end else begin : g_inner
			assign right_value[i] = cell_value[i + 1];
		end

		mmmes_cell #(
			.IDX(i),
			.CW (CW),
			.IW (IW)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.count      (count_q),
			.pos        (pos),
			.left_value (left_value[i]),
			.left_lt    (left_lt[i]),
			.right_value(right_value[i]),
			.value      (cell_value[i]),
			.lt         (cell_lt[i]),
			.pick       (cell_pick[i])
		);
	end

	// Gather the extracted value
	mmmes_or_tree #(
		.N(CAPACITY)
	) u_tree (
		.clk       (clk),
		.arst_n    (arst_n),
		.leaves    (cell_pick),
		.in_tag    (in_tag),
		.take      (take),
		.root_value(root_value),
		.root_tag  (root_tag),
		.busy      (tree_busy)
	);

	// Output register
	assign take = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= root_tag.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && root_tag.valid) begin
			rsp_q.result_value <= root_value;
			rsp_q.status       <= root_tag.status;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_extract_dec: assert property (@(posedge clk) disable iff (!arst_n)
		ext_ok |=> (count_q == $past(count_m1)))
		else $error("extract did not remove one entry");

	a_reject_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !add_ok && !ext_ok) |=> $stable(count_q))
		else $error("rejected item changed the entry count");

	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.status != mmmes_pkg::ST_OK)) |-> (rsp.result_value == '0))
		else $error("nonzero value with failure status");

endmodule
